@@ rtl/fss_pkg.sv @@
// ----------------------------------------------------------------------------
// fss_pkg
// shared widths, constants, types and bit-count helpers for the fingerprint
// similarity statistics block
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int WORD_W      = 64;
    localparam int CNT_W       = 16;
    localparam int POP_W       = $clog2(WORD_W + 1);
    localparam int Q_W         = 17;
    localparam int NUM_W       = CNT_W + Q_W;
    localparam int DIV_STEPS   = Q_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [Q_W-1:0]   Q_ONE   = {1'b1, {(Q_W-1){1'b0}}};

    // totals of one fingerprint pair, handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] intersect_count;
        logic [CNT_W-1:0] union_count;
        logic [CNT_W-1:0] weight_a;
        logic [CNT_W-1:0] weight_b;
        logic [CNT_W-1:0] growth_count;
        logic             a_contains_b;
        logic             any_shared;
    } fss_snap_t;

    // cleared totals: nothing counted yet, containment holds
    localparam fss_snap_t SNAP_CLEAR = '{
        intersect_count: '0,
        union_count:     '0,
        weight_a:        '0,
        weight_b:        '0,
        growth_count:    '0,
        a_contains_b:    1'b1,
        any_shared:      1'b0
    };

    // tree bit count over one word
    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] s1;
        logic [WORD_W-1:0] s2;
        logic [WORD_W-1:0] s3;
        logic [WORD_W-1:0] s4;
        logic [WORD_W-1:0] s5;
        logic [WORD_W-1:0] s6;
        s1 = x - ((x >> 1) & 64'h5555_5555_5555_5555);
        s2 = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
        s3 = (s2 + (s2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        s4 = s3 + (s3 >> 8);
        s5 = s4 + (s4 >> 16);
        s6 = s5 + (s5 >> 32);
        return s6[POP_W-1:0];
    endfunction

    // counter add that sticks at the top of its range
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                 input logic [POP_W-1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, acc} + {{(CNT_W+1-POP_W){1'b0}}, inc};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

endpackage

@@ rtl/fss_if.sv @@
// ----------------------------------------------------------------------------
// fss_pair_if / fss_stats_if
// valid-ready channels for word pairs in and similarity results out
// ----------------------------------------------------------------------------
interface fss_pair_if;
    logic                        valid;
    logic                        ready;
    logic [fss_pkg::WORD_W-1:0]  word_a;
    logic [fss_pkg::WORD_W-1:0]  word_b;
    logic                        last;

    modport source (output valid, output word_a, output word_b, output last,
                    input ready);
    modport sink   (input valid, input word_a, input word_b, input last,
                    output ready);
endinterface

interface fss_stats_if;
    logic                       valid;
    logic                       ready;
    logic [fss_pkg::CNT_W-1:0]  intersect_count;
    logic [fss_pkg::CNT_W-1:0]  union_count;
    logic [fss_pkg::CNT_W-1:0]  weight_a;
    logic [fss_pkg::CNT_W-1:0]  weight_b;
    logic [fss_pkg::CNT_W-1:0]  growth_count;
    logic                       a_contains_b;
    logic                       any_shared;
    logic [fss_pkg::Q_W-1:0]    tanimoto;
    logic [fss_pkg::Q_W-1:0]    dice;

    modport source (output valid, output intersect_count, output union_count,
                    output weight_a, output weight_b, output growth_count,
                    output a_contains_b, output any_shared, output tanimoto,
                    output dice, input ready);
    modport sink   (input valid, input intersect_count, input union_count,
                    input weight_a, input weight_b, input growth_count,
                    input a_contains_b, input any_shared, input tanimoto,
                    input dice, output ready);
endinterface

@@ rtl/fss_front.sv @@
// ----------------------------------------------------------------------------
// fss_front
// accepts word pairs, accumulates bit counts and flags, pushes totals on last
// ----------------------------------------------------------------------------
module fss_front (
    input  logic                 clk,
    input  logic                 rst_n,
    fss_pair_if.sink             pairs,
    output logic                 push_valid,
    input  logic                 push_ready,
    output fss_pkg::fss_snap_t   push_data
);

    fss_pkg::fss_snap_t acc_reg;
    fss_pkg::fss_snap_t acc_next;
    fss_pkg::fss_snap_t sum;
    logic [fss_pkg::WORD_W-1:0] both;
    logic [fss_pkg::WORD_W-1:0] extra;
    logic accept;

    assign pairs.ready = push_ready;
    assign accept      = pairs.valid && pairs.ready;

    always_comb
    begin
        both  = pairs.word_a & pairs.word_b;
        extra = pairs.word_b & ~pairs.word_a;

        sum.intersect_count = fss_pkg::sat_add(acc_reg.intersect_count,
                                               fss_pkg::popcount64(both));
        sum.union_count     = fss_pkg::sat_add(acc_reg.union_count,
                                 fss_pkg::popcount64(pairs.word_a | pairs.word_b));
        sum.weight_a        = fss_pkg::sat_add(acc_reg.weight_a,
                                               fss_pkg::popcount64(pairs.word_a));
        sum.weight_b        = fss_pkg::sat_add(acc_reg.weight_b,
                                               fss_pkg::popcount64(pairs.word_b));
        sum.growth_count    = fss_pkg::sat_add(acc_reg.growth_count,
                                               fss_pkg::popcount64(extra));
        sum.a_contains_b    = acc_reg.a_contains_b && (extra == '0);
        sum.any_shared      = acc_reg.any_shared || (both != '0);

        acc_next = acc_reg;
        if (accept)
        begin
            if (pairs.last)
            begin
                acc_next = fss_pkg::SNAP_CLEAR;
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    assign push_valid = accept && pairs.last;
    assign push_data  = sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= fss_pkg::SNAP_CLEAR;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ rtl/fss_queue.sv @@
// ----------------------------------------------------------------------------
// fss_queue
// short first-in first-out buffer of fingerprint totals between front and back
// ----------------------------------------------------------------------------
module fss_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  fss_pkg::fss_snap_t   push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output fss_pkg::fss_snap_t   pop_data
);

    localparam logic [fss_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        fss_pkg::QUEUE_PTR_W'(fss_pkg::QUEUE_DEPTH - 1);
    localparam logic [fss_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        fss_pkg::QUEUE_CNT_W'(fss_pkg::QUEUE_DEPTH);

    fss_pkg::fss_snap_t entry_reg [fss_pkg::QUEUE_DEPTH];
    logic [fss_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [fss_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [fss_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [fss_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [fss_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [fss_pkg::QUEUE_CNT_W-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/fss_div.sv @@
// ----------------------------------------------------------------------------
// fss_div
// restoring divider, one quotient bit per cycle, for the Q1.16 ratios
// ----------------------------------------------------------------------------
module fss_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fss_pkg::NUM_W-1:0]   numer,
    input  logic [fss_pkg::Q_W-1:0]     denom,
    output logic                        busy,
    output logic [fss_pkg::Q_W-1:0]     quotient
);

    logic [fss_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [fss_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [fss_pkg::Q_W-1:0] rem_reg;
    logic [fss_pkg::Q_W-1:0] rem_next;
    logic [fss_pkg::Q_W-1:0] num_reg;
    logic [fss_pkg::Q_W-1:0] num_next;
    logic [fss_pkg::Q_W-1:0] den_reg;
    logic [fss_pkg::Q_W-1:0] den_next;
    logic [fss_pkg::Q_W-1:0] quo_reg;
    logic [fss_pkg::Q_W-1:0] quo_next;
    logic [fss_pkg::Q_W:0]   trial;
    logic [fss_pkg::Q_W:0]   diff;
    logic                    fits;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    always_comb
    begin
        trial = {rem_reg, num_reg[fss_pkg::Q_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        cnt_next = cnt_reg;
        rem_next = rem_reg;
        num_next = num_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (start)
        begin
            // upper part is below the divisor whenever the quotient fits
            cnt_next = fss_pkg::DIV_CNT_W'(fss_pkg::DIV_STEPS);
            rem_next = {1'b0, numer[fss_pkg::NUM_W-1:fss_pkg::Q_W]};
            num_next = numer[fss_pkg::Q_W-1:0];
            den_next = denom;
            quo_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? diff[fss_pkg::Q_W-1:0] : trial[fss_pkg::Q_W-1:0];
            num_next = {num_reg[fss_pkg::Q_W-2:0], 1'b0};
            quo_next = {quo_reg[fss_pkg::Q_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule

@@ rtl/fss_back.sv @@
// ----------------------------------------------------------------------------
// fss_back
// takes totals from the queue, forms both ratios and holds the result word
// ----------------------------------------------------------------------------
module fss_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  fss_pkg::fss_snap_t   pop_data,
    fss_stats_if.source          stats
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    fss_pkg::fss_snap_t snap_reg;
    fss_pkg::fss_snap_t snap_next;
    logic out_valid_reg;
    logic out_valid_next;
    fss_pkg::fss_snap_t out_snap_reg;
    logic [fss_pkg::Q_W-1:0] out_tan_reg;
    logic [fss_pkg::Q_W-1:0] out_dice_reg;
    logic load_out;
    logic start;
    logic tan_busy;
    logic dice_busy;
    logic [fss_pkg::Q_W-1:0] tan_quo;
    logic [fss_pkg::Q_W-1:0] dice_quo;
    logic [fss_pkg::Q_W-1:0] tan_val;
    logic [fss_pkg::Q_W-1:0] dice_val;
    logic [fss_pkg::Q_W-1:0] tan_den;
    logic [fss_pkg::Q_W-1:0] dice_den;
    logic [fss_pkg::Q_W-1:0] held_tan_den;
    logic [fss_pkg::Q_W-1:0] held_dice_den;

    assign tan_den  = {1'b0, pop_data.union_count};
    assign dice_den = {1'b0, pop_data.weight_a} + {1'b0, pop_data.weight_b};
    assign held_tan_den  = {1'b0, snap_reg.union_count};
    assign held_dice_den = {1'b0, snap_reg.weight_a} + {1'b0, snap_reg.weight_b};

    fss_div u_tan_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .numer    ({1'b0, pop_data.intersect_count, {(fss_pkg::Q_W-1){1'b0}}}),
        .denom    (tan_den),
        .busy     (tan_busy),
        .quotient (tan_quo)
    );

    fss_div u_dice_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .numer    ({pop_data.intersect_count, {fss_pkg::Q_W{1'b0}}}),
        .denom    (dice_den),
        .busy     (dice_busy),
        .quotient (dice_quo)
    );

    // empty union reads as 1.0, zero weight sum as 0
    always_comb
    begin
        if (held_tan_den == '0)
        begin
            tan_val = fss_pkg::Q_ONE;
        end
        else if (tan_quo > fss_pkg::Q_ONE)
        begin
            tan_val = fss_pkg::Q_ONE;
        end
        else
        begin
            tan_val = tan_quo;
        end

        if (held_dice_den == '0)
        begin
            dice_val = '0;
        end
        else if (dice_quo > fss_pkg::Q_ONE)
        begin
            dice_val = fss_pkg::Q_ONE;
        end
        else
        begin
            dice_val = dice_quo;
        end
    end

    assign pop_ready = (state_reg == ST_IDLE);
    assign start     = pop_valid && pop_ready;
    assign load_out  = (state_reg == ST_HOLD) && (!out_valid_reg || stats.ready);

    always_comb
    begin
        state_next     = state_reg;
        snap_next      = snap_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && stats.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    snap_next  = pop_data;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!tan_busy && !dice_busy)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        if (load_out)
        begin
            out_snap_reg <= snap_reg;
            out_tan_reg  <= tan_val;
            out_dice_reg <= dice_val;
        end
    end

    assign stats.valid           = out_valid_reg;
    assign stats.intersect_count = out_snap_reg.intersect_count;
    assign stats.union_count     = out_snap_reg.union_count;
    assign stats.weight_a        = out_snap_reg.weight_a;
    assign stats.weight_b        = out_snap_reg.weight_b;
    assign stats.growth_count    = out_snap_reg.growth_count;
    assign stats.a_contains_b    = out_snap_reg.a_contains_b;
    assign stats.any_shared      = out_snap_reg.any_shared;
    assign stats.tanimoto        = out_tan_reg;
    assign stats.dice            = out_dice_reg;

endmodule

@@ rtl/fingerprint_similarity_stats.sv @@
// ----------------------------------------------------------------------------
// fingerprint_similarity_stats
// bit-count statistics and Tanimoto / Dice similarity of two fingerprints
// ----------------------------------------------------------------------------
// throughput: one word pair per cycle; the front stalls only while two
//   finished fingerprints still wait in the queue for the back end
// result path: after its last pair is accepted, a fingerprint's totals pass the queue,
//   the 17-step one-bit-per-cycle dividers, the hold state and the result register
// back end: takes a new fingerprint from the queue only once the last one has left the hold state
// reset: asynchronous, clears counters (containment flag to 1) and the queue
module fingerprint_similarity_stats (
    input  logic         clk,
    input  logic         rst_n,
    fss_pair_if.sink     pairs,
    fss_stats_if.source  stats
);

    // totals of one finished fingerprint pair, front to queue
    logic               push_valid;
    logic               push_ready;
    fss_pkg::fss_snap_t push_data;

    // queue to back end
    logic               pop_valid;
    logic               pop_ready;
    fss_pkg::fss_snap_t pop_data;

    // front: popcount tree and saturating accumulators, one pair a cycle while the queue has room
    fss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pairs      (pairs),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouples word intake from the long divide
    fss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: both ratios in parallel, then the registered result word
    fss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .stats     (stats)
    );

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for fingerprint_similarity_stats: word pairs are driven
// over the pair channel, each finished fingerprint is predicted in the bench
// and its result word is compared field by field on the stats channel
// ----------------------------------------------------------------------------
module tb_top;

    // run shape
    localparam int unsigned PHASE_WORDS    = 130;   // random words per idling phase
    localparam int unsigned HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int unsigned PRESSURE_FPS   = 16;    // one-word fingerprints under hold
    localparam int unsigned DRAIN_CYCLES   = 40;    // settling time after the drain
    localparam int unsigned QUIET_LIMIT    = 4000;  // cycles with no handshake at all
    localparam int unsigned REPORT_LIMIT   = 10;

    localparam logic [fss_pkg::WORD_W-1:0] ALL_ONES = '1;
    localparam logic [fss_pkg::WORD_W-1:0] ALT_HI   = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [fss_pkg::WORD_W-1:0] ALT_LO   = 64'h5555_5555_5555_5555;
    localparam logic [fss_pkg::WORD_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    // one result word as the bench sees it
    typedef struct packed {
        logic [fss_pkg::CNT_W-1:0] n_common;
        logic [fss_pkg::CNT_W-1:0] n_either;
        logic [fss_pkg::CNT_W-1:0] n_a;
        logic [fss_pkg::CNT_W-1:0] n_b;
        logic [fss_pkg::CNT_W-1:0] n_added;
        logic                      contains;
        logic                      shared;
        logic [fss_pkg::Q_W-1:0]   tani;
        logic [fss_pkg::Q_W-1:0]   dice;
    } sim_stats_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [fss_pkg::WORD_W-1:0] a;
        logic [fss_pkg::WORD_W-1:0] b;
        logic                       last;
        logic                       typed;
        sim_stats_t                 want;
    } pair_row_t;

    // how the two words of a random pair relate
    typedef enum int unsigned {
        MIX_RANDOM,
        MIX_SPARSE,
        MIX_SUBSET,
        MIX_DISJOINT,
        MIX_EQUAL,
        MIX_EDGE,
        MIX_DENSE
    } word_mix_e;

    localparam sim_stats_t NO_WANT = '0;
    localparam int unsigned N_ROWS = 20;

    // directed rows: extremes, empty union, zero weight sum, containment,
    // disjoint words, zero-padded tails and multi-word fingerprints
    localparam pair_row_t DIRECTED [0:N_ROWS-1] = '{
        // both empty: tanimoto is one, dice is zero
        '{64'h0, 64'h0, 1'b1, 1'b1,
          '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 17'd65536, 17'd0}},
        // full overlap
        '{ALL_ONES, ALL_ONES, 1'b1, 1'b1,
          '{16'd64, 16'd64, 16'd64, 16'd64, 16'd0, 1'b1, 1'b1, 17'd65536, 17'd65536}},
        // a empty, b full
        '{64'h0, ALL_ONES, 1'b1, 1'b1,
          '{16'd0, 16'd64, 16'd0, 16'd64, 16'd64, 1'b0, 1'b0, 17'd0, 17'd0}},
        // a full, b empty
        '{ALL_ONES, 64'h0, 1'b1, 1'b1,
          '{16'd0, 16'd64, 16'd64, 16'd0, 16'd0, 1'b1, 1'b0, 17'd0, 17'd0}},
        // interleaved, no shared bit
        '{ALT_HI, ALT_LO, 1'b1, 1'b1,
          '{16'd0, 16'd64, 16'd32, 16'd32, 16'd32, 1'b0, 1'b0, 17'd0, 17'd0}},
        // top bit only
        '{TOP_BIT, TOP_BIT, 1'b1, 1'b1,
          '{16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 1'b1, 1'b1, 17'd65536, 17'd65536}},
        // bottom bit of a only
        '{64'h1, 64'h0, 1'b1, 1'b1,
          '{16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 1'b1, 1'b0, 17'd0, 17'd0}},
        // b grows past a, truncated dice
        '{64'h0F, 64'hFF, 1'b1, 1'b1,
          '{16'd4, 16'd8, 16'd4, 16'd8, 16'd4, 1'b0, 1'b1, 17'd32768, 17'd43690}},
        // truncated tanimoto
        '{64'h7, 64'h1, 1'b1, 1'b1,
          '{16'd1, 16'd3, 16'd3, 16'd1, 16'd0, 1'b1, 1'b1, 17'd21845, 17'd32768}},
        // three words, zero-padded tail
        '{64'hFFFF_FFFF_0000_0000, 64'hFFFF_0000_FFFF_0000, 1'b0, 1'b0, NO_WANT},
        '{64'h1, 64'h1, 1'b0, 1'b0, NO_WANT},
        '{64'h0, 64'h0, 1'b1, 1'b0, NO_WANT},
        // containment held over several words
        '{ALL_ONES, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, NO_WANT},
        '{64'hF0F0_F0F0_F0F0_F0F0, 64'hF000_F000_F000_F000, 1'b0, 1'b0, NO_WANT},
        '{64'h0, 64'h0, 1'b1, 1'b0, NO_WANT},
        // containment lost in the final word only
        '{ALL_ONES, ALL_ONES, 1'b0, 1'b0, NO_WANT},
        '{64'h1, 64'h3, 1'b1, 1'b0, NO_WANT},
        // shared bit in the first word only
        '{64'h1, 64'h1, 1'b0, 1'b0, NO_WANT},
        '{64'h2, 64'h4, 1'b1, 1'b0, NO_WANT},
        // exact complements
        '{64'hDEAD_BEEF_0BAD_F00D, 64'h2152_4110_F452_0FF2, 1'b1, 1'b0, NO_WANT}
    };

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    fss_pair_if  pairs_if ();
    fss_stats_if stats_if ();

    fingerprint_similarity_stats dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pairs (pairs_if),
        .stats (stats_if)
    );

    // idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        rx_hold        = 1'b0;

    // running tallies of the fingerprint pair in flight
    logic [fss_pkg::CNT_W-1:0] tally_common;
    logic [fss_pkg::CNT_W-1:0] tally_either;
    logic [fss_pkg::CNT_W-1:0] tally_a;
    logic [fss_pkg::CNT_W-1:0] tally_b;
    logic [fss_pkg::CNT_W-1:0] tally_added;
    logic                      b_within_a;
    logic                      overlap_seen;

    // result words still owed by the block, oldest first
    sim_stats_t pending_stats [$];

    // bookkeeping
    int unsigned words_sent       = 0;
    int unsigned fingerprints     = 0;
    int unsigned run_words        = 0;
    int unsigned longest_run      = 0;
    int unsigned results_checked  = 0;
    int unsigned mismatch_count   = 0;
    int unsigned saturated_seen   = 0;
    int unsigned contained_seen   = 0;
    int unsigned unshared_seen    = 0;
    int unsigned input_stalls     = 0;
    int unsigned quiet_cycles     = 0;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    task automatic clear_tallies();
        tally_common = '0;
        tally_either = '0;
        tally_a      = '0;
        tally_b      = '0;
        tally_added  = '0;
        b_within_a   = 1'b1;
        overlap_seen = 1'b0;
    endtask

    // counters stick at the top of their range
    function automatic logic [fss_pkg::CNT_W-1:0] bump_count(
        input logic [fss_pkg::CNT_W-1:0] acc, input int unsigned n);
        int unsigned sum;
        sum = acc + n;
        return (sum > fss_pkg::CNT_MAX) ? fss_pkg::CNT_MAX : sum[fss_pkg::CNT_W-1:0];
    endfunction

    // fold one word pair in; on last, form the ratios and start over
    task automatic tally_word(input logic [fss_pkg::WORD_W-1:0] a,
                              input logic [fss_pkg::WORD_W-1:0] b,
                              input logic is_last, output logic done,
                              output sim_stats_t res);
        logic [fss_pkg::WORD_W-1:0] both;
        logic [fss_pkg::WORD_W-1:0] extra;
        longint unsigned            num;
        longint unsigned            den;
        longint unsigned            ratio;
        both  = a & b;
        extra = b & ~a;
        tally_common = bump_count(tally_common, $countones(both));
        tally_either = bump_count(tally_either, $countones(a | b));
        tally_a      = bump_count(tally_a, $countones(a));
        tally_b      = bump_count(tally_b, $countones(b));
        tally_added  = bump_count(tally_added, $countones(extra));
        if (extra != '0)
            b_within_a = 1'b0;
        if (both != '0)
            overlap_seen = 1'b1;
        done = is_last;
        res  = '0;
        if (is_last)
        begin
            // tanimoto: empty union counts as identical
            num = tally_common;
            if (tally_either != '0)
                ratio = (num << 16) / tally_either;
            else
                ratio = fss_pkg::Q_ONE;
            if (ratio > fss_pkg::Q_ONE)
                ratio = fss_pkg::Q_ONE;
            res.tani = ratio[fss_pkg::Q_W-1:0];
            // dice: zero weight sum gives zero
            den = longint'(tally_a) + longint'(tally_b);
            if (den != 0)
                ratio = (num << 17) / den;
            else
                ratio = 0;
            if (ratio > fss_pkg::Q_ONE)
                ratio = fss_pkg::Q_ONE;
            res.dice     = ratio[fss_pkg::Q_W-1:0];
            res.n_common = tally_common;
            res.n_either = tally_either;
            res.n_a      = tally_a;
            res.n_b      = tally_b;
            res.n_added  = tally_added;
            res.contains = b_within_a;
            res.shared   = overlap_seen;
            clear_tallies();
        end
    endtask

    // ------------------------------------------------------------------------
    // pair channel driver
    // ------------------------------------------------------------------------

    // offer one word, wait for the handshake, then queue what it owes
    task automatic send_word(input logic [fss_pkg::WORD_W-1:0] a,
                             input logic [fss_pkg::WORD_W-1:0] b,
                             input logic is_last, input logic typed,
                             input sim_stats_t want);
        sim_stats_t predicted;
        logic       done;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pairs_if.valid <= 1'b0;
            @(posedge clk);
        end
        pairs_if.valid  <= 1'b1;
        pairs_if.word_a <= a;
        pairs_if.word_b <= b;
        pairs_if.last   <= is_last;
        // ready is read at the edge, before the block updates it
        do
            @(posedge clk);
        while (!pairs_if.ready);
        tally_word(a, b, is_last, done, predicted);
        words_sent++;
        run_words++;
        if (done)
        begin
            pending_stats.push_back(typed ? want : predicted);
            fingerprints++;
            if (run_words > longest_run)
                longest_run = run_words;
            run_words = 0;
        end
    endtask

    function automatic logic [fss_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic pick_pair(input word_mix_e mix, output logic [fss_pkg::WORD_W-1:0] a,
                             output logic [fss_pkg::WORD_W-1:0] b);
        case (mix)
            MIX_SPARSE:
            begin
                a = rand_word() & rand_word() & rand_word();
                b = rand_word() & rand_word() & rand_word();
            end
            MIX_SUBSET:
            begin
                a = rand_word();
                b = a & rand_word();
            end
            MIX_DISJOINT:
            begin
                a = rand_word();
                b = rand_word() & ~a;
            end
            MIX_EQUAL:
            begin
                a = rand_word();
                b = a;
            end
            MIX_EDGE:
            begin
                a = ($urandom_range(1) == 0) ? ALL_ONES : '0;
                b = ($urandom_range(2) == 0) ? ~a : rand_word();
            end
            MIX_DENSE:
            begin
                a = rand_word() | rand_word();
                b = rand_word() | rand_word();
            end
            default:
            begin
                a = rand_word();
                b = rand_word();
            end
        endcase
    endtask

    // random fingerprints, mostly short, each leaning toward one relation
    task automatic send_random_fps(input int unsigned word_budget);
        int unsigned                sent;
        int unsigned                len;
        word_mix_e                  fp_mix;
        word_mix_e                  mix;
        logic [fss_pkg::WORD_W-1:0] a;
        logic [fss_pkg::WORD_W-1:0] b;
        sent = 0;
        while (sent < word_budget)
        begin
            len    = ($urandom_range(15) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            fp_mix = word_mix_e'($urandom_range(int'(MIX_DENSE)));
            for (int unsigned i = 0; i < len; i++)
            begin
                mix = ($urandom_range(3) == 0) ? word_mix_e'($urandom_range(int'(MIX_DENSE)))
                                               : fp_mix;
                pick_pair(mix, a, b);
                send_word(a, b, i == len - 1, 1'b0, NO_WANT);
            end
            sent += len;
        end
    endtask

    // longer than 1024 words and dense enough to pin counters at the top;
    // one flavor fills the overlap counters, the other the growth counter
    task automatic send_saturating(input logic growth_side);
        int unsigned                len;
        logic [fss_pkg::WORD_W-1:0] a;
        logic [fss_pkg::WORD_W-1:0] b;
        len = 1060 + $urandom_range(0, 40);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (growth_side)
            begin
                a = ($urandom_range(31) == 0) ? rand_word() : '0;
                b = ALL_ONES;
            end
            else
            begin
                a = ALL_ONES;
                b = ($urandom_range(31) == 0) ? rand_word() : ALL_ONES;
            end
            send_word(a, b, i == len - 1, 1'b0, NO_WANT);
        end
    endtask

    // ------------------------------------------------------------------------
    // stats channel: receiver, checker, watchdog
    // ------------------------------------------------------------------------

    // ready follows the stall knob unless a hold-off is running
    always @(posedge clk)
    begin
        if (!rst_n || rx_hold)
            stats_if.ready <= 1'b0;
        else
            stats_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic flag_field(input string field, input logic [fss_pkg::Q_W-1:0] want,
                              input logic [fss_pkg::Q_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     results_checked, field, want, got);
    endtask

    always @(posedge clk)
    begin
        sim_stats_t want;
        if (rst_n && pairs_if.valid && !pairs_if.ready)
            input_stalls++;
        if (rst_n && stats_if.valid && stats_if.ready)
        begin
            if (pending_stats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result word: intersect %0d union %0d tanimoto %0d",
                             stats_if.intersect_count, stats_if.union_count,
                             stats_if.tanimoto);
            end
            else
            begin
                want = pending_stats.pop_front();
                if (stats_if.intersect_count !== want.n_common)
                    flag_field("intersect_count", want.n_common, stats_if.intersect_count);
                if (stats_if.union_count !== want.n_either)
                    flag_field("union_count", want.n_either, stats_if.union_count);
                if (stats_if.weight_a !== want.n_a)
                    flag_field("weight_a", want.n_a, stats_if.weight_a);
                if (stats_if.weight_b !== want.n_b)
                    flag_field("weight_b", want.n_b, stats_if.weight_b);
                if (stats_if.growth_count !== want.n_added)
                    flag_field("growth_count", want.n_added, stats_if.growth_count);
                if (stats_if.a_contains_b !== want.contains)
                    flag_field("a_contains_b", want.contains, stats_if.a_contains_b);
                if (stats_if.any_shared !== want.shared)
                    flag_field("any_shared", want.shared, stats_if.any_shared);
                if (stats_if.tanimoto !== want.tani)
                    flag_field("tanimoto", want.tani, stats_if.tanimoto);
                if (stats_if.dice !== want.dice)
                    flag_field("dice", want.dice, stats_if.dice);
                if (want.n_common == fss_pkg::CNT_MAX || want.n_either == fss_pkg::CNT_MAX
                    || want.n_added == fss_pkg::CNT_MAX)
                    saturated_seen++;
                if (want.contains)
                    contained_seen++;
                if (!want.shared)
                    unshared_seen++;
            end
            results_checked++;
        end
    end

    // any handshake on either channel counts as progress
    always @(posedge clk)
    begin
        if ((pairs_if.valid && pairs_if.ready) || (stats_if.valid && stats_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d results still owed",
                     QUIET_LIMIT, pending_stats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        pairs_if.valid  <= 1'b0;
        pairs_if.word_a <= '0;
        pairs_if.word_b <= '0;
        pairs_if.last   <= 1'b0;
        clear_tallies();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int unsigned r = 0; r < N_ROWS; r++)
            send_word(DIRECTED[r].a, DIRECTED[r].b, DIRECTED[r].last,
                      DIRECTED[r].typed, DIRECTED[r].want);

        // random fingerprints under each idling pattern
        send_idle_pct = 0;  recv_stall_pct = 0;
        send_random_fps(PHASE_WORDS);
        send_idle_pct = 62; recv_stall_pct = 0;
        send_random_fps(PHASE_WORDS);
        send_idle_pct = 0;  recv_stall_pct = 62;
        send_random_fps(PHASE_WORDS);
        send_idle_pct = 34; recv_stall_pct = 34;
        send_random_fps(PHASE_WORDS);

        // back pressure: receiver holds off while one-word fingerprints keep
        // coming, so the queue of totals fills and the pair input stalls
        send_idle_pct = 0;  recv_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int unsigned f = 0; f < PRESSURE_FPS; f++)
            send_word(rand_word(), rand_word(), 1'b1, 1'b0, NO_WANT);

        // counter saturation on a very long fingerprint
        send_idle_pct = 10; recv_stall_pct = 10;
        send_saturating(1'b0);
        send_random_fps(PHASE_WORDS / 2);

        pairs_if.valid <= 1'b0;

        // drain, then give the block time to show any stray word
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d word pairs in %0d fingerprints (longest %0d words), %0d results checked",
                 words_sent, fingerprints, longest_run, results_checked);
        $display("%0d saturated, %0d contained, %0d with no shared bit, %0d input stall cycles",
                 saturated_seen, contained_seen, unshared_seen, input_stalls);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
